### hdl/mlmtd_pkg.sv
// ----------------------------------------------------------------------------
// mlmtd_pkg
// Shared constants, types and helper functions of the trellis decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mlmtd_pkg;

    localparam int BLOCK_LEN    = 40;
    localparam int METRIC_WIDTH = 32;
    localparam int SAMPLE_WIDTH = 8;
    localparam int NSTATES      = 8;
    localparam int STORE_LEN    = BLOCK_LEN + 3;
    localparam int AMP_WIDTH    = 7;
    localparam int IN_WIDTH     = 8;
    localparam int IDX_WIDTH    = 6;
    localparam int AW           = $clog2(STORE_LEN);
    localparam int KW           = $clog2(BLOCK_LEN);
    localparam int DW           = SAMPLE_WIDTH + 2;
    localparam int SQW          = 2 * DW;
    localparam int BASEW        = (SQW + 1 > METRIC_WIDTH) ? SQW + 1 : METRIC_WIDTH;
    localparam int SUMW         = BASEW + 2;
    localparam int ROWW         = NSTATES * METRIC_WIDTH;
    localparam int AMP_RESET    = 28;

    typedef logic signed [METRIC_WIDTH-1:0] t_metric;
    typedef logic [NSTATES-1:0][METRIC_WIDTH-1:0] t_row;

    typedef enum logic [3:0] {
        ST_LOAD, ST_BINIT, ST_BRD, ST_BBM, ST_BACS,
        ST_FINIT, ST_FRD, ST_FBM, ST_FACS, ST_FOUT
    } t_state;

    typedef struct packed {
        logic            smp_we;
        logic [AW-1:0]   smp_waddr;
        logic [AW-1:0]   smp_raddr;
        logic            amp_latch;
        logic            beta_init;
        logic            beta_step;
        logic            beta_we;
        logic [KW-1:0]   beta_addr;
        logic            bm_load;
        logic            alpha_init;
        logic            fwd_step;
        logic            out_load;
        logic            out_last;
        logic [KW-1:0]   k;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic t_metric sat_metric(input logic signed [SUMW-1:0] x);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        hi = SUMW'({1'b0, {(METRIC_WIDTH-1){1'b1}}});
        lo = -hi - SUMW'(1);
        if (x > hi) begin
            sat_metric = METRIC_WIDTH'(hi);
        end else if (x < lo) begin
            sat_metric = METRIC_WIDTH'(lo);
        end else begin
            sat_metric = METRIC_WIDTH'(x);
        end
    endfunction

    function automatic t_metric metric_min();
        metric_min = {1'b1, {(METRIC_WIDTH-1){1'b0}}};
    endfunction

endpackage
`default_nettype wire

### hdl/mlmtd_ram.sv
// ----------------------------------------------------------------------------
// mlmtd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mlmtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/mlmtd_ctrl.sv
// ----------------------------------------------------------------------------
// mlmtd_ctrl
// Sequencer for sample loading, the backward pass and the forward/decision pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mlmtd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire mlmtd_pkg::t_sts i_sts,
    output mlmtd_pkg::t_cmd     o_cmd
);
    mlmtd_pkg::t_state r_state, n_state;
    logic [mlmtd_pkg::AW-1:0] r_cnt, n_cnt;
    logic [mlmtd_pkg::KW-1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlmtd_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_k        = r_k;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        o_cmd.smp_waddr = r_cnt;
        o_cmd.k         = r_k;
        o_cmd.beta_addr = r_k;
        o_cmd.smp_raddr = mlmtd_pkg::AW'(r_k);
        case (r_state)
            mlmtd_pkg::ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.smp_we = 1'b1;
                    if (r_cnt == mlmtd_pkg::AW'(mlmtd_pkg::STORE_LEN - 1)) begin
                        o_cmd.amp_latch = 1'b1;
                        n_cnt   = '0;
                        n_state = mlmtd_pkg::ST_BINIT;
                    end else begin
                        n_cnt = r_cnt + mlmtd_pkg::AW'(1);
                    end
                end
            end
            mlmtd_pkg::ST_BINIT: begin
                o_cmd.beta_init = 1'b1;
                o_cmd.beta_we   = 1'b1;
                o_cmd.beta_addr = mlmtd_pkg::KW'(mlmtd_pkg::BLOCK_LEN - 1);
                n_k     = mlmtd_pkg::KW'(mlmtd_pkg::BLOCK_LEN - 2);
                n_state = mlmtd_pkg::ST_BRD;
            end
            mlmtd_pkg::ST_BRD: begin
                o_cmd.smp_raddr = mlmtd_pkg::AW'(r_k) + mlmtd_pkg::AW'(1);
                n_state = mlmtd_pkg::ST_BBM;
            end
            mlmtd_pkg::ST_BBM: begin
                o_cmd.smp_raddr = mlmtd_pkg::AW'(r_k) + mlmtd_pkg::AW'(1);
                o_cmd.bm_load   = 1'b1;
                n_state = mlmtd_pkg::ST_BACS;
            end
            mlmtd_pkg::ST_BACS: begin
                o_cmd.beta_step = 1'b1;
                o_cmd.beta_we   = 1'b1;
                if (r_k == '0) begin
                    n_state = mlmtd_pkg::ST_FINIT;
                end else begin
                    n_k     = r_k - mlmtd_pkg::KW'(1);
                    n_state = mlmtd_pkg::ST_BRD;
                end
            end
            mlmtd_pkg::ST_FINIT: begin
                o_cmd.alpha_init = 1'b1;
                n_k     = '0;
                n_state = mlmtd_pkg::ST_FRD;
            end
            mlmtd_pkg::ST_FRD: begin
                n_state = mlmtd_pkg::ST_FBM;
            end
            mlmtd_pkg::ST_FBM: begin
                o_cmd.bm_load = 1'b1;
                n_state = mlmtd_pkg::ST_FACS;
            end
            mlmtd_pkg::ST_FACS: begin
                o_cmd.fwd_step = 1'b1;
                n_state = mlmtd_pkg::ST_FOUT;
            end
            mlmtd_pkg::ST_FOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_k == mlmtd_pkg::KW'(mlmtd_pkg::BLOCK_LEN - 1)) begin
                        o_cmd.out_last = 1'b1;
                        n_k     = '0;
                        n_state = mlmtd_pkg::ST_LOAD;
                    end else begin
                        n_k     = r_k + mlmtd_pkg::KW'(1);
                        n_state = mlmtd_pkg::ST_FRD;
                    end
                end
            end
            default: begin
                n_state = mlmtd_pkg::ST_LOAD;
            end
        endcase
    end
endmodule
`default_nettype wire

### hdl/mlmtd_datapath.sv
// ----------------------------------------------------------------------------
// mlmtd_datapath
// Sample and beta stores, branch metrics, add-compare-select and decisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mlmtd_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mlmtd_pkg::AMP_WIDTH-1:0]     i_cfg_data,
    input  wire logic signed [mlmtd_pkg::IN_WIDTH-1:0] i_soft_sample,
    input  wire mlmtd_pkg::t_cmd                     i_cmd,
    output mlmtd_pkg::t_sts                          o_sts,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_decoded_bit,
    output logic [mlmtd_pkg::IDX_WIDTH-1:0]          o_bit_index,
    output logic                                     o_last_bit
);
    localparam int SW = mlmtd_pkg::SAMPLE_WIDTH;
    localparam int MW = mlmtd_pkg::METRIC_WIDTH;
    localparam int NS = mlmtd_pkg::NSTATES;

    logic [mlmtd_pkg::AMP_WIDTH-1:0] r_amp_cfg, r_amp;
    logic [2:0] r_hard, r_zero;
    logic signed [SW-1:0] w_sample, w_smp_rd;
    logic [SW-1:0] w_smp_rd_u;
    mlmtd_pkg::t_row r_beta, r_alpha, w_beta_rd, w_beta_new, w_alpha_new, w_beta_wdata;
    mlmtd_pkg::t_row w_beta_ini, r_v0, r_v1, w_v0, w_v1;
    mlmtd_pkg::t_metric r_bm0, r_bm1;
    logic signed [mlmtd_pkg::DW-1:0] w_d0, w_d1;
    logic signed [mlmtd_pkg::SQW-1:0] w_sq0, w_sq1;
    logic [2:0] w_tail;
    logic r_out_valid, r_out_bit, r_out_last;
    logic [mlmtd_pkg::IDX_WIDTH-1:0] r_out_idx;
    logic w_dec;

    always_comb begin
        logic signed [16:0] ext;
        logic signed [16:0] hi;
        ext = 17'(i_soft_sample);
        hi  = 17'((1 << (SW - 1)) - 1);
        if (ext > hi) begin
            w_sample = SW'(hi);
        end else if (ext < -hi - 17'sd1) begin
            w_sample = SW'(-hi - 17'sd1);
        end else begin
            w_sample = SW'(ext);
        end
    end

    mlmtd_ram #(.WIDTH(SW), .DEPTH(mlmtd_pkg::STORE_LEN)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.smp_we),
        .i_waddr (i_cmd.smp_waddr),
        .i_wdata (w_sample),
        .i_raddr (i_cmd.smp_raddr),
        .o_rdata (w_smp_rd_u)
    );
    assign w_smp_rd = $signed(w_smp_rd_u);

    mlmtd_ram #(.WIDTH(mlmtd_pkg::ROWW), .DEPTH(mlmtd_pkg::BLOCK_LEN)) u_beta_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.beta_we),
        .i_waddr (i_cmd.beta_addr),
        .i_wdata (w_beta_wdata),
        .i_raddr (i_cmd.beta_addr),
        .o_rdata (w_beta_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_cfg <= mlmtd_pkg::AMP_WIDTH'(mlmtd_pkg::AMP_RESET);
        end else if (i_cfg_we) begin
            r_amp_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.amp_latch) begin
            r_amp <= r_amp_cfg;
        end
        if (i_cmd.smp_we) begin
            if (i_cmd.smp_waddr == mlmtd_pkg::AW'(mlmtd_pkg::BLOCK_LEN)) begin
                r_hard[0] <= w_sample > 0;
                r_zero[0] <= w_sample == 0;
            end
            if (i_cmd.smp_waddr == mlmtd_pkg::AW'(mlmtd_pkg::BLOCK_LEN + 1)) begin
                r_hard[1] <= w_sample > 0;
                r_zero[1] <= w_sample == 0;
            end
            if (i_cmd.smp_waddr == mlmtd_pkg::AW'(mlmtd_pkg::BLOCK_LEN + 2)) begin
                r_hard[2] <= w_sample > 0;
                r_zero[2] <= w_sample == 0;
            end
        end
    end

    assign w_tail = {r_hard[2], r_hard[1], r_hard[0] ^ r_hard[2]};

    always_comb begin
        for (int m = 0; m < NS; m++) begin
            if (r_zero != 3'b000 || w_tail == 3'(m)) begin
                w_beta_ini[m] = '0;
            end else begin
                w_beta_ini[m] = mlmtd_pkg::metric_min();
            end
        end
    end

    assign w_d1  = mlmtd_pkg::DW'(w_smp_rd) - mlmtd_pkg::DW'($signed({1'b0, r_amp}));
    assign w_d0  = mlmtd_pkg::DW'(w_smp_rd) + mlmtd_pkg::DW'($signed({1'b0, r_amp}));
    assign w_sq1 = w_d1 * w_d1;
    assign w_sq0 = w_d0 * w_d0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.bm_load) begin
            r_bm1 <= mlmtd_pkg::sat_metric(-mlmtd_pkg::SUMW'(w_sq1));
            r_bm0 <= mlmtd_pkg::sat_metric(-mlmtd_pkg::SUMW'(w_sq0));
        end
    end

    always_comb begin
        logic [2:0] st, p, nx;
        logic cb;
        logic signed [mlmtd_pkg::SUMW-1:0] c0, c1;
        for (int m = 0; m < NS; m++) begin
            st = 3'(m);
            p  = {st[1:0], st[2] ^ st[0]};
            cb = p[2] ^ p[1];
            c0 = mlmtd_pkg::SUMW'($signed(r_alpha[p]))
               + mlmtd_pkg::SUMW'(cb ? r_bm1 : r_bm0);
            p  = {st[1:0], st[2] ^ st[0] ^ 1'b1};
            cb = 1'b1 ^ p[2] ^ p[1];
            c1 = mlmtd_pkg::SUMW'($signed(r_alpha[p]))
               + mlmtd_pkg::SUMW'(cb ? r_bm1 : r_bm0);
            w_alpha_new[m] = (mlmtd_pkg::sat_metric(c1) > mlmtd_pkg::sat_metric(c0))
                           ? mlmtd_pkg::sat_metric(c1) : mlmtd_pkg::sat_metric(c0);

            cb = st[2] ^ st[1];
            nx = {st[1] ^ st[0], st[2], st[1]};
            c0 = mlmtd_pkg::SUMW'(cb ? r_bm1 : r_bm0)
               + mlmtd_pkg::SUMW'($signed(r_beta[nx]));
            w_v0[m] = mlmtd_pkg::sat_metric(mlmtd_pkg::SUMW'($signed(r_alpha[m])) + c0
                    - mlmtd_pkg::SUMW'($signed(r_beta[nx]))
                    + mlmtd_pkg::SUMW'($signed(w_beta_rd[nx])));
            nx = {1'b1 ^ st[1] ^ st[0], st[2], st[1]};
            c1 = mlmtd_pkg::SUMW'(cb ? r_bm0 : r_bm1)
               + mlmtd_pkg::SUMW'($signed(r_beta[nx]));
            w_v1[m] = mlmtd_pkg::sat_metric(mlmtd_pkg::SUMW'($signed(r_alpha[m])) + c1
                    - mlmtd_pkg::SUMW'($signed(r_beta[nx]))
                    + mlmtd_pkg::SUMW'($signed(w_beta_rd[nx])));
            w_beta_new[m] = (mlmtd_pkg::sat_metric(c1) > mlmtd_pkg::sat_metric(c0))
                          ? mlmtd_pkg::sat_metric(c1) : mlmtd_pkg::sat_metric(c0);
        end
    end

    assign w_beta_wdata = i_cmd.beta_init ? w_beta_ini : w_beta_new;

    always_ff @(posedge i_clk) begin
        if (i_cmd.beta_init) begin
            r_beta <= w_beta_ini;
        end else if (i_cmd.beta_step) begin
            r_beta <= w_beta_new;
        end
        if (i_cmd.alpha_init) begin
            for (int m = 0; m < NS; m++) begin
                r_alpha[m] <= (m == 0) ? '0 : mlmtd_pkg::metric_min();
            end
        end else if (i_cmd.fwd_step) begin
            r_alpha <= w_alpha_new;
            r_v0    <= w_v0;
            r_v1    <= w_v1;
        end
    end

    always_comb begin
        mlmtd_pkg::t_metric b0, b1;
        b0 = $signed(r_v0[0]);
        b1 = $signed(r_v1[0]);
        for (int m = 1; m < NS; m++) begin
            if ($signed(r_v0[m]) > b0) begin
                b0 = $signed(r_v0[m]);
            end
            if ($signed(r_v1[m]) > b1) begin
                b1 = $signed(r_v1[m]);
            end
        end
        w_dec = b1 > b0;
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_bit  <= w_dec;
            r_out_idx  <= mlmtd_pkg::IDX_WIDTH'(i_cmd.k);
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_decoded_bit = r_out_bit;
    assign o_bit_index   = r_out_idx;
    assign o_last_bit    = r_out_last;
endmodule
`default_nettype wire

### hdl/max_log_map_trellis_decoder_core.sv
// ----------------------------------------------------------------------------
// max_log_map_trellis_decoder_core
// Max-log trellis decoder for an eight-state recursive code, one block at a time.
// ----------------------------------------------------------------------------
// A block loads one sample per cycle, BLOCK_LEN+3 samples in all.
// The backward pass then sets the last beta row and runs ST_BRD, ST_BBM, ST_BACS per trellis step.
// After ST_FINIT setup, each bit passes ST_FRD, ST_FBM, ST_FACS, ST_FOUT; ST_FOUT waits on stalls.
// Each step waits on a registered memory read, a branch-metric register and the metric registers.
// Synchronous active-low reset returns to loading with an empty sample count.
`timescale 1ns / 1ps
`default_nettype none
module max_log_map_trellis_decoder_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [mlmtd_pkg::AMP_WIDTH-1:0]       i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [mlmtd_pkg::IN_WIDTH-1:0] i_soft_sample,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic                                       o_decoded_bit,
    output logic [mlmtd_pkg::IDX_WIDTH-1:0]            o_bit_index,
    output logic                                       o_last_bit
);
    mlmtd_pkg::t_cmd w_cmd;
    mlmtd_pkg::t_sts w_sts;

    mlmtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mlmtd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_soft_sample (i_soft_sample),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_decoded_bit (o_decoded_bit),
        .o_bit_index   (o_bit_index),
        .o_last_bit    (o_last_bit)
    );
endmodule
`default_nettype wire
